@@ design/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/ldss_pkg.sv @@
`default_nettype none
package ldss_pkg;

  // Result kinds on the line
  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_LATCH   = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  // Latch pulse count limits and reset value
  localparam logic [4:0] LATCH_MIN   = 5'd8;
  localparam logic [4:0] LATCH_MAX   = 5'd16;
  localparam logic [4:0] LATCH_RESET = 5'd16;

  // Byte counter width
  localparam int unsigned CNT_W = 5;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // Register index of latch_pulses
  localparam logic REG_LATCH = 1'b0;

  // One queued byte with its frame-end mark
  typedef struct packed {
    logic       frame_end;
    logic [7:0] level;
  } q_item_t;

endpackage
`default_nettype wire

@@ design/ldss_front.sv @@
`default_nettype none
module ldss_front #(
  parameter int unsigned LED_COUNT = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [7:0]       in_level,
  input  wire logic             q_full,
  output      logic             q_push,
  output      ldss_pkg::q_item_t q_wdata
);

  logic [ldss_pkg::CNT_W-1:0] byte_count_r;
  logic [ldss_pkg::CNT_W-1:0] byte_count_nxt;
  logic [ldss_pkg::CNT_W:0]   count_inc;
  logic                       frame_end;

  // Accept whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Mark the frame's last byte, also when the counter has run past the end
  assign count_inc = {1'b0, byte_count_r} + {{ldss_pkg::CNT_W{1'b0}}, 1'b1};
  assign frame_end = count_inc >= (ldss_pkg::CNT_W + 1)'(LED_COUNT);

  assign q_wdata.frame_end = frame_end;
  assign q_wdata.level     = in_level;

  // Advance the place in the frame on each accepted transaction
  always_comb begin
    byte_count_nxt = byte_count_r;
    if (q_push) begin
      byte_count_nxt = frame_end ? '0 : count_inc[ldss_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
    end else begin
      byte_count_r <= byte_count_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/ldss_fifo.sv @@
`default_nettype none
`include "assert_macros.svh"
module ldss_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire ldss_pkg::q_item_t wdata,
  output      logic              full,
  input  wire logic              pop,
  output      logic              valid,
  output      ldss_pkg::q_item_t rdata
);

  localparam int unsigned PTR_W = $clog2(ldss_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(ldss_pkg::Q_DEPTH + 1);

  ldss_pkg::q_item_t mem_r [ldss_pkg::Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = count_r == CNT_W'(ldss_pkg::Q_DEPTH);
  assign valid = count_r != '0;
  assign rdata = mem_r[rd_ptr_r];

  // Wrap pointers at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(ldss_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(ldss_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, count_r != '0, "pop from empty queue")
  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, !full, "push into full queue")

endmodule
`default_nettype wire

@@ design/ldss_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module ldss_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [3:0]        latch_last,
  input  wire logic              q_valid,
  input  wire ldss_pkg::q_item_t q_rdata,
  output      logic              q_pop,
  output      logic              out_valid,
  input  wire logic              out_ready,
  output      logic [1:0]        out_kind,
  output      logic              out_data_bit,
  output      logic              out_last
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DATA  = 5'b00010,
    S_TRAIL = 5'b00100,
    S_LATCH = 5'b01000,
    S_REL   = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       fend_r, fend_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] out_kind_r, out_kind_nxt;
  logic       out_bit_r, out_bit_nxt;
  logic       out_last_r, out_last_nxt;
  logic       adv;
  logic       done;

  // Output register moves when empty or taken
  assign adv = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_data_bit = out_bit_r;
  assign out_last     = out_last_r;

  // Current item finishes this cycle and the next byte may load
  always_comb begin
    case (state_r)
      S_IDLE:  done = 1'b1;
      S_DATA:  done = (cnt_r == 4'd7) && !fend_r;
      S_REL:   done = 1'b1;
      default: done = 1'b0;
    endcase
  end

  assign q_pop = adv && done && q_valid;

  // Emit one pulse per cycle while the output register can advance, and step through the trailer
  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    cnt_nxt       = cnt_r;
    fend_nxt      = fend_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_bit_nxt   = out_bit_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = state_r != S_IDLE;
      out_bit_nxt   = 1'b0;
      out_last_nxt  = 1'b0;
      out_kind_nxt  = ldss_pkg::KIND_DATA;
      case (state_r)
        S_DATA: begin
          out_bit_nxt  = shift_r[7];
          out_last_nxt = (cnt_r == 4'd7) && !fend_r;
          shift_nxt    = {shift_r[6:0], 1'b0};
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == 4'd7) begin
            cnt_nxt   = '0;
            state_nxt = fend_r ? S_TRAIL : S_IDLE;
          end
        end
        S_TRAIL: begin
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == 4'd7) begin
            cnt_nxt   = '0;
            state_nxt = S_LATCH;
          end
        end
        S_LATCH: begin
          out_kind_nxt = ldss_pkg::KIND_LATCH;
          cnt_nxt      = cnt_r + 1'b1;
          if (cnt_r == latch_last) begin
            cnt_nxt   = '0;
            state_nxt = S_REL;
          end
        end
        S_REL: begin
          out_kind_nxt = ldss_pkg::KIND_RELEASE;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
      // Load the next byte behind the one finishing
      if (q_pop) begin
        shift_nxt = q_rdata.level;
        fend_nxt  = q_rdata.frame_end;
        cnt_nxt   = '0;
        state_nxt = S_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    cnt_r      <= cnt_nxt;
    fend_r     <= fend_nxt;
    out_kind_r <= out_kind_nxt;
    out_bit_r  <= out_bit_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPLIES(a_release_is_last, clk, rst_n,
    out_valid_r && (out_kind_r == ldss_pkg::KIND_RELEASE), out_last_r,
    "clock release without last mark")
  `ASSERT_IMPLIES(a_latch_count, clk, rst_n, state_r == S_LATCH, cnt_r <= latch_last,
    "latch counter ran past its limit")

endmodule
`default_nettype wire

@@ design/led_driver_serial_frame_sender_unit.sv @@
`default_nettype none
// An accepted byte passes through the queue and the serializer to the output register.
// The serializer sends one pulse per cycle while out_tready takes them; a frame's
// last byte adds a zero trailer, latch_pulses (clamped to 8..16) latch pulses and a release.
// A two-entry queue lets bytes be accepted while the serializer is busy.
// Reset: synchronous active-low rst_n clears frame counter, queue and serializer;
// latch_pulses returns to 16.
module led_driver_serial_frame_sender_unit #(
  parameter int unsigned LED_COUNT = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: [7:0] level
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  // out_tdata: [0] data_bit, [7:1] zero
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [7:0]  out_tdata,
  // out_tuser: [1:0] kind
  output      logic [1:0]  out_tuser,
  output      logic        out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output      logic [31:0] cfg_prdata,
  output      logic        cfg_pready
);

  logic [4:0]        latch_r, latch_nxt;
  logic [4:0]        latch_n;
  logic [3:0]        latch_last;
  logic              q_full, q_push, q_valid, q_pop;
  ldss_pkg::q_item_t q_wdata, q_rdata;
  logic              data_bit;

  // Configuration register access
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == ldss_pkg::REG_LATCH) ? {27'd0, latch_r} : 32'd0;

  always_comb begin
    latch_nxt = latch_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == ldss_pkg::REG_LATCH)) begin
      latch_nxt = cfg_pwdata[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= ldss_pkg::LATCH_RESET;
    end else begin
      latch_r <= latch_nxt;
    end
  end

  // Clamp the latch pulse count and give the back part its final index
  always_comb begin
    if (latch_r > ldss_pkg::LATCH_MAX) begin
      latch_n = ldss_pkg::LATCH_MAX;
    end else if (latch_r < ldss_pkg::LATCH_MIN) begin
      latch_n = ldss_pkg::LATCH_MIN;
    end else begin
      latch_n = latch_r;
    end
  end

  assign latch_last = 4'(latch_n - 5'd1);

  ldss_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_level (in_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  ldss_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  ldss_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .latch_last   (latch_last),
    .q_valid      (q_valid),
    .q_rdata      (q_rdata),
    .q_pop        (q_pop),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_kind     (out_tuser),
    .out_data_bit (data_bit),
    .out_last     (out_tlast)
  );

  assign out_tdata = {7'd0, data_bit};

endmodule
`default_nettype wire
